>>> rtl/core/espr_pkg.sv
// Shared types, constants and a helper function of the encoder speed PI regulator.
package espr_pkg;

    localparam int unsigned ENC_BITS       = 12;
    localparam int unsigned ENC_COUNTS     = 1 << ENC_BITS;
    localparam int unsigned WRAP_THRESHOLD = 1000;
    localparam int unsigned RPM_PER_HZ     = 60;
    localparam int unsigned Q8_BITS        = 8;
    // Multiplying by 256 and dividing by the count per turn is one right shift.
    localparam int unsigned SPEED_SHIFT    = ENC_BITS - Q8_BITS;
    localparam int unsigned GAIN_SHIFT     = 16;
    localparam int unsigned RATE_BITS      = 17;
    localparam int unsigned RATE_RESET     = 3000;

    localparam int unsigned MUL_IN_BITS    = 33;
    localparam int unsigned MUL_OUT_BITS   = 64;

    typedef enum logic [1:0] {
        CFG_INTEGRAL_GAIN     = 2'd0,
        CFG_PROPORTIONAL_GAIN = 2'd1,
        CFG_SAMPLE_RATE       = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic        [ENC_BITS-1:0] encoder_position;
        logic signed [31:0]         speed_setpoint;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] drive_value;
        logic signed [31:0] measured_speed;
    } out_item_t;

    // Arithmetic right shift that rounds to nearest, ties away from zero.
    // A negative value gets one less bias so that the floor of the shift lands
    // on the away-from-zero neighbor at a tie.
    function automatic logic signed [MUL_OUT_BITS-1:0] round_shr(
        input logic signed [MUL_OUT_BITS-1:0] v,
        input int unsigned                    sh
    );
        logic signed [MUL_OUT_BITS-1:0] bias;
        logic signed [MUL_OUT_BITS-1:0] sum;
        begin
            bias = (MUL_OUT_BITS'(1) << (sh - 1))
                 - {{(MUL_OUT_BITS-1){1'b0}}, v[MUL_OUT_BITS-1]};
            sum  = v + bias;
            return sum >>> sh;
        end
    endfunction

endpackage

>>> rtl/core/espr_mul.sv
// Shared signed multiplier with a registered product.
module espr_mul (
    input  logic                                       aclk,
    input  logic                                       en,
    input  logic signed [espr_pkg::MUL_IN_BITS-1:0]    op_a,
    input  logic signed [espr_pkg::MUL_IN_BITS-1:0]    op_b,
    output logic signed [espr_pkg::MUL_OUT_BITS-1:0]   product
);

    logic signed [2*espr_pkg::MUL_IN_BITS-1:0] full;
    logic signed [espr_pkg::MUL_OUT_BITS-1:0]  product_reg;

    assign full    = op_a * op_b;
    assign product = product_reg;

    // Every product the sequencer forms fits in the lower 64 bits.
    always_ff @(posedge aclk) begin
        if (en) begin
            product_reg <= full[espr_pkg::MUL_OUT_BITS-1:0];
        end
    end

endmodule

>>> rtl/core/encoder_speed_pi_regulator.sv
// Top level of the encoder speed PI regulator: sequencer, state and handshakes.
//
// One request on the s_ channel carries an absolute encoder position and a
// speed setpoint for one control period. The block differences the position
// against the previous one, unwraps a jump across the turn boundary, scales
// it to rpm in Q.8, and runs a PI law on the speed error. The m_ channel
// returns the saturated drive value and the measured speed.
// A request is taken only while s_ready is high, and s_ready is high only
// while the sequencer is idle, so a new request waits until the last one
// is through. From acceptance to m_valid, every step goes through the single
// shared 33x33 multiplier or one adder, which rounds and saturates in all but
// the error step; one step per cycle unless the drive step waits on the receiver.
// The result sits in an output register, so the next request is accepted
// while it waits; if the receiver still stalls when that next result is
// ready, the sequencer holds until the output register frees.
// The cfg port writes one gain or the sample rate, as cfg_index selects; write
// it only while the block is idle. Reset clears the previous position and
// the integrator, sets both gains to zero and the sample rate to 3000 Hz.
module encoder_speed_pi_regulator (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  espr_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output espr_pkg::out_item_t   m_data
);

    localparam int unsigned DIFF_BITS = espr_pkg::ENC_BITS + 1;
    localparam int unsigned MW        = espr_pkg::MUL_IN_BITS;
    localparam int unsigned PW        = espr_pkg::MUL_OUT_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_RATE,
        ST_MUL_RPM,
        ST_SPEED,
        ST_ERROR,
        ST_MUL_KI,
        ST_MUL_KP,
        ST_INTEG,
        ST_DRIVE
    } state_t;

    state_t                               state_reg, state_next;
    logic signed [31:0]                   ki_reg, ki_next;
    logic signed [31:0]                   kp_reg, kp_next;
    logic [espr_pkg::RATE_BITS-1:0]       rate_reg, rate_next;
    logic [espr_pkg::ENC_BITS-1:0]        prev_pos_reg, prev_pos_next;
    logic signed [47:0]                   integ_reg, integ_next;
    logic signed [DIFF_BITS-1:0]          diff_reg, diff_next;
    logic signed [31:0]                   setpoint_reg, setpoint_next;
    logic signed [31:0]                   speed_reg, speed_next;
    logic signed [32:0]                   err_reg, err_next;
    logic signed [47:0]                   inc_reg, inc_next;
    logic signed [47:0]                   prop_reg, prop_next;
    logic                                 m_valid_reg, m_valid_next;
    espr_pkg::out_item_t                  out_reg, out_next;

    logic                                 mul_en;
    logic signed [MW-1:0]                 mul_a;
    logic signed [MW-1:0]                 mul_b;
    logic signed [PW-1:0]                 product;
    logic signed [PW-1:0]                 rounded;

    logic signed [DIFF_BITS:0]            diff_raw;
    logic signed [DIFF_BITS:0]            diff_unwrapped;
    logic signed [49:0]                   integ_sum;
    logic signed [48:0]                   drive_sum;
    logic                                 in_accept;
    logic                                 out_free;

    espr_mul u_mul (
        .aclk    (aclk),
        .en      (mul_en),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // Position difference with the turn boundary unwrapped.
    always_comb begin
        diff_raw = $signed({2'b00, s_data.encoder_position})
                 - $signed({2'b00, prev_pos_reg});
        if (diff_raw > $signed((DIFF_BITS+1)'(espr_pkg::WRAP_THRESHOLD))) begin
            diff_unwrapped = diff_raw - $signed((DIFF_BITS+1)'(espr_pkg::ENC_COUNTS));
        end else if (diff_raw < -$signed((DIFF_BITS+1)'(espr_pkg::WRAP_THRESHOLD))) begin
            diff_unwrapped = diff_raw + $signed((DIFF_BITS+1)'(espr_pkg::ENC_COUNTS));
        end else begin
            diff_unwrapped = diff_raw;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_MUL_RATE: begin
                mul_en = 1'b1;
                mul_a  = MW'(diff_reg);
                mul_b  = $signed({{(MW-espr_pkg::RATE_BITS){1'b0}}, rate_reg});
            end
            ST_MUL_RPM: begin
                mul_en = 1'b1;
                mul_a  = product[MW-1:0];
                mul_b  = $signed(MW'(espr_pkg::RPM_PER_HZ));
            end
            ST_MUL_KI: begin
                mul_en = 1'b1;
                mul_a  = err_reg;
                mul_b  = MW'(ki_reg);
            end
            ST_MUL_KP: begin
                mul_en = 1'b1;
                mul_a  = err_reg;
                mul_b  = MW'(kp_reg);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign rounded   = espr_pkg::round_shr(product,
                           (state_reg == ST_SPEED) ? espr_pkg::SPEED_SHIFT
                                                   : espr_pkg::GAIN_SHIFT);
    assign integ_sum = 50'(integ_reg) + 50'(inc_reg);
    assign drive_sum = 49'(prop_reg) + 49'(integ_reg);

    always_comb begin
        state_next    = state_reg;
        ki_next       = ki_reg;
        kp_next       = kp_reg;
        rate_next     = rate_reg;
        prev_pos_next = prev_pos_reg;
        integ_next    = integ_reg;
        diff_next     = diff_reg;
        setpoint_next = setpoint_reg;
        speed_next    = speed_reg;
        err_next      = err_reg;
        inc_next      = inc_reg;
        prop_next     = prop_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_next      = out_reg;

        if (cfg_wr_en) begin
            case (espr_pkg::cfg_idx_t'(cfg_index))
                espr_pkg::CFG_INTEGRAL_GAIN:     ki_next   = $signed(cfg_wdata);
                espr_pkg::CFG_PROPORTIONAL_GAIN: kp_next   = $signed(cfg_wdata);
                espr_pkg::CFG_SAMPLE_RATE:
                    rate_next = cfg_wdata[espr_pkg::RATE_BITS-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    diff_next     = diff_unwrapped[DIFF_BITS-1:0];
                    prev_pos_next = s_data.encoder_position;
                    setpoint_next = s_data.speed_setpoint;
                    state_next    = ST_MUL_RATE;
                end
            end
            ST_MUL_RATE: state_next = ST_MUL_RPM;
            ST_MUL_RPM:  state_next = ST_SPEED;
            ST_SPEED: begin
                if (rounded > 64'sh0000_0000_7FFF_FFFF) begin
                    speed_next = 32'sh7FFF_FFFF;
                end else if (rounded < -64'sh0000_0000_8000_0000) begin
                    speed_next = -32'sh8000_0000;
                end else begin
                    speed_next = rounded[31:0];
                end
                state_next = ST_ERROR;
            end
            ST_ERROR: begin
                err_next   = 33'(setpoint_reg) - 33'(speed_reg);
                state_next = ST_MUL_KI;
            end
            ST_MUL_KI: state_next = ST_MUL_KP;
            ST_MUL_KP: begin
                inc_next   = rounded[47:0];
                state_next = ST_INTEG;
            end
            ST_INTEG: begin
                if (integ_sum > 50'sh0_7FFF_FFFF_FFFF) begin
                    integ_next = 48'sh7FFF_FFFF_FFFF;
                end else if (integ_sum < -50'sh0_8000_0000_0000) begin
                    integ_next = -48'sh8000_0000_0000;
                end else begin
                    integ_next = integ_sum[47:0];
                end
                prop_next  = rounded[47:0];
                state_next = ST_DRIVE;
            end
            ST_DRIVE: begin
                if (out_free) begin
                    if (drive_sum > 49'sh0_0000_7FFF_FFFF) begin
                        out_next.drive_value = 32'sh7FFF_FFFF;
                    end else if (drive_sum < -49'sh0_0000_8000_0000) begin
                        out_next.drive_value = -32'sh8000_0000;
                    end else begin
                        out_next.drive_value = drive_sum[31:0];
                    end
                    out_next.measured_speed = speed_reg;
                    m_valid_next            = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ki_reg       <= '0;
            kp_reg       <= '0;
            rate_reg     <= espr_pkg::RATE_BITS'(espr_pkg::RATE_RESET);
            prev_pos_reg <= '0;
            integ_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ki_reg       <= ki_next;
            kp_reg       <= kp_next;
            rate_reg     <= rate_next;
            prev_pos_reg <= prev_pos_next;
            integ_reg    <= integ_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        diff_reg     <= diff_next;
        setpoint_reg <= setpoint_next;
        speed_reg    <= speed_next;
        err_reg      <= err_next;
        inc_reg      <= inc_next;
        prop_reg     <= prop_next;
        out_reg      <= out_next;
    end

    // The sequencer is busy for the whole computation of an accepted request.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_ready)
        else $error("request accepted while the previous one is in progress");

    // A new result appears only from the final sequencer step.
    a_result_from_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DRIVE))
        else $error("result raised outside the drive step");

    // A finished result waits while the output register is still occupied.
    a_drive_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRIVE && m_valid_reg && !m_ready) |=> state_reg == ST_DRIVE)
        else $error("result overwrote a pending output");

endmodule

>>> verif/encoder_speed_pi_regulator_test.sv
// Self-checking random testbench of the encoder speed PI regulator.
module encoder_speed_pi_regulator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint WRAP_LIMIT  = espr_pkg::WRAP_THRESHOLD;
    localparam longint TURN_COUNTS = espr_pkg::ENC_COUNTS;
    localparam longint RPM_SCALE   = espr_pkg::RPM_PER_HZ;
    localparam longint Q8_SCALE    = longint'(1) << espr_pkg::Q8_BITS;
    localparam longint GAIN_DIV    = longint'(1) << espr_pkg::GAIN_SHIFT;
    localparam longint INTEG_MAX   = (longint'(1) << 47) - 1;
    localparam longint INTEG_MIN   = -(longint'(1) << 47);
    localparam longint WORD_MAX    = (longint'(1) << 31) - 1;
    localparam longint WORD_MIN    = -(longint'(1) << 31);
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     HOLD_CYCLES = 400;

    // Tracks the regulator state and the drive and speed results still owed.
    class pi_loop_tracker;
        longint              ki;
        longint              kp;
        longint              rate_hz;
        logic [11:0]         last_position;
        longint              integrator;
        espr_pkg::out_item_t owed_results[$];
        int                  errors;

        function new();
            ki            = 0;
            kp            = 0;
            rate_hz       = espr_pkg::RATE_RESET;
            last_position = '0;
            integrator    = 0;
            errors        = 0;
        endfunction

        function void set_register(espr_pkg::cfg_idx_t idx, logic [31:0] value);
            case (idx)
                espr_pkg::CFG_INTEGRAL_GAIN: begin
                    ki = longint'(signed'(value));
                end
                espr_pkg::CFG_PROPORTIONAL_GAIN: begin
                    kp = longint'(signed'(value));
                end
                espr_pkg::CFG_SAMPLE_RATE: begin
                    rate_hz = longint'(value[espr_pkg::RATE_BITS-1:0]);
                end
                default: begin
                end
            endcase
        endfunction

        // Division by a positive divisor, nearest, ties away from zero.
        function longint round_div(longint v, longint d);
            if (v >= 0)
                return (v + d / 2) / d;
            return -((-v + d / 2) / d);
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void note_request(espr_pkg::in_item_t req);
            longint              diff;
            longint              speed;
            longint              err;
            longint              prop;
            longint              drive;
            espr_pkg::out_item_t result;
            diff = longint'(req.encoder_position) - longint'(last_position);
            last_position = req.encoder_position;
            // A jump larger than the threshold crossed the turn boundary.
            if (diff > WRAP_LIMIT)
                diff = diff - TURN_COUNTS;
            else if (diff < -WRAP_LIMIT)
                diff = diff + TURN_COUNTS;
            speed = round_div(diff * RPM_SCALE * rate_hz * Q8_SCALE, TURN_COUNTS);
            speed = clamp(speed, WORD_MIN, WORD_MAX);
            err = longint'(req.speed_setpoint) - speed;
            integrator = clamp(integrator + round_div(ki * err, GAIN_DIV),
                               INTEG_MIN, INTEG_MAX);
            prop = round_div(kp * err, GAIN_DIV);
            drive = clamp(prop + integrator, WORD_MIN, WORD_MAX);
            result.drive_value    = drive[31:0];
            result.measured_speed = speed[31:0];
            owed_results.push_back(result);
        endfunction

        function void check_result(espr_pkg::out_item_t got);
            espr_pkg::out_item_t want;
            if (owed_results.size() == 0) begin
                errors++;
                $error("result with no request outstanding: drive %0d speed %0d",
                       got.drive_value, got.measured_speed);
                return;
            end
            want = owed_results.pop_front();
            if (got.drive_value !== want.drive_value) begin
                errors++;
                $error("drive_value: expected %0d, actual %0d",
                       want.drive_value, got.drive_value);
            end
            if (got.measured_speed !== want.measured_speed) begin
                errors++;
                $error("measured_speed: expected %0d, actual %0d",
                       want.measured_speed, got.measured_speed);
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [1:0]          cfg_index = '0;
    logic [31:0]         cfg_wdata = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    espr_pkg::in_item_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    espr_pkg::out_item_t m_data;

    pi_loop_tracker tracker = new();
    int          s_idle_pct   = 26;
    int          m_idle_pct   = 26;
    bit          hold_off_req = 1'b0;
    int          cycle_count  = 0;
    logic [11:0] gen_position = '0;

    encoder_speed_pi_regulator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.note_request(s_data);
            if (m_valid && m_ready)
                tracker.check_result(m_data);
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    task automatic write_register(input espr_pkg::cfg_idx_t idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        tracker.set_register(idx, value);
    endtask

    task automatic apply_config(input logic [31:0] ki, input logic [31:0] kp,
                                input logic [31:0] rate);
        write_register(espr_pkg::CFG_INTEGRAL_GAIN, ki);
        write_register(espr_pkg::CFG_PROPORTIONAL_GAIN, kp);
        write_register(espr_pkg::CFG_SAMPLE_RATE, rate);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_request(input logic [11:0] pos, input logic [31:0] setpoint);
        espr_pkg::in_item_t req;
        req.encoder_position = pos;
        req.speed_setpoint   = setpoint;
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Lets every owed result arrive, with no new requests driven.
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [11:0] pick_position(input logic [11:0] prev);
        int sel;
        int step;
        sel = $urandom_range(99);
        if (sel < 60) begin
            step = int'($urandom_range(100)) - 50;
        end else if (sel < 85) begin
            step = 999 + int'($urandom_range(3));
            if ($urandom_range(1))
                step = -step;
        end else begin
            return 12'($urandom_range(4095));
        end
        return 12'(prev + step);
    endfunction

    function automatic logic [31:0] pick_setpoint();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            case ($urandom_range(3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (sel < 60)
            return 32'(int'($urandom_range(1 << 21)) - (1 << 20));
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_gain();
        int sel;
        sel = $urandom_range(99);
        if (sel < 20) begin
            case ($urandom_range(4))
                0: return 32'h0000_0000;
                1: return 32'h0000_0001;
                2: return 32'hFFFF_FFFF;
                3: return 32'h7FFF_FFFF;
                default: return 32'h8000_0000;
            endcase
        end
        if (sel < 65)
            return 32'(int'($urandom_range(1 << 18)) - (1 << 17));
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_rate();
        if ($urandom_range(99) < 25) begin
            case ($urandom_range(3))
                0: return 32'd0;
                1: return 32'd1;
                2: return 32'd100000;
                default: return 32'd131071;
            endcase
        end
        return $urandom_range(131071, 1);
    endfunction

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Plain gains: no-wrap and wrap around the threshold, full-turn jumps.
        apply_config(32'h0001_0000, 32'h0002_0000, 32'd3000);
        send_request(12'd0,    32'h0000_0000);
        send_request(12'd1000, 32'd2560000);
        send_request(12'd0,    32'h7FFF_FFFF);
        send_request(12'd1001, 32'h8000_0000);
        send_request(12'd0,    32'hFFFF_FFFF);
        send_request(12'd4095, 32'h0000_0000);
        send_request(12'd0,    32'h0000_0000);
        send_request(12'd2048, 32'h0001_0000);
        drain();

        // Zero sample rate with unit gains: rounding ties of the gain products.
        apply_config(32'h0000_0001, 32'hFFFF_FFFF, 32'd0);
        send_request(12'd2048, 32'd32768);
        send_request(12'd2048, -32'sd32768);
        send_request(12'd3000, 32'd98304);
        send_request(12'd100,  -32'sd98304);
        send_request(12'd100,  32'h7FFF_FFFF);
        send_request(12'd100,  32'h8000_0000);
        drain();

        // Extreme gains and rate drive the integrator and drive into saturation.
        apply_config(32'h7FFF_FFFF, 32'h8000_0000, 32'd131071);
        send_request(12'd1100, 32'h8000_0000);
        send_request(12'd100,  32'h8000_0000);
        send_request(12'd1100, 32'h7FFF_FFFF);
        send_request(12'd2100, 32'h7FFF_FFFF);
        send_request(12'd3100, 32'h7FFF_FFFF);
        send_request(12'd4095, 32'h8000_0000);
        send_request(12'd0,    32'h8000_0000);
        drain();

        apply_config(32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
        send_request(12'd1,    32'h7FFF_FFFF);
        send_request(12'd0,    32'h8000_0000);
        send_request(12'd4095, 32'h0000_0000);
        gen_position = 12'd4095;
        drain();

        for (int phase = 0; phase < 12; phase++) begin
            apply_config(pick_gain(), pick_gain(), pick_rate());
            s_idle_pct = (phase == 4) ? 0 : 26;
            m_idle_pct = (phase == 4) ? 0 : 26;
            if (phase == 7)
                hold_off_req = 1'b1;
            repeat (120) begin
                gen_position = pick_position(gen_position);
                send_request(gen_position, pick_setpoint());
            end
            drain();
        end

        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
